FILE: rtl/core/tmtw_pkg.sv
// ----------------------------------------------------------------------------
// tmtw_pkg
// Shared types and constants for the text mode terminal writer.
// ----------------------------------------------------------------------------
package tmtw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int FILL_W  = $clog2(COLUMNS + 1);
  localparam int ADDR_W  = $clog2(CELLS);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] RESET_COLOR  = 8'h0A;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
  } out_t;

  // per physical row: blanking color and count of written cells from column 0
  typedef struct packed {
    logic [7:0]        color;
    logic [FILL_W-1:0] fill;
  } meta_t;

endpackage

FILE: rtl/core/tmtw_ram.sv
// ----------------------------------------------------------------------------
// tmtw_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tmtw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/text_mode_terminal_writer.sv
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// Character-cell terminal: puts characters at a cursor, scrolls through a
// rotating top-row pointer, and reads back single screen cells.
// ----------------------------------------------------------------------------
// sequence: a put passes through the write state, and the scroll state when it
//   scrolls; a read passes through the ram address and ram data states
// a new beat is taken only in idle, when busy is low, so each put or read runs
//   through one work state per step (write, scroll, ram address, ram data)
//   before the next beat is accepted
// reset: cursor to row 0 column 0, color 0x0A, all row-valid bits cleared so
//   every cell reads as a space in 0x0A at once; no clearing pass
module text_mode_terminal_writer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  tmtw_pkg::in_t  in_data,
  output logic           out_strobe,
  output tmtw_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_data
);
  import tmtw_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_PUT     = 5'b00010,
    ST_SCROLL  = 5'b00100,
    ST_RD_ADDR = 5'b01000,
    ST_RD_DATA = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [7:0]        text_color_r, text_color_nxt;
  logic [7:0]        cur_color_r, cur_color_nxt;
  logic [ROW_W-1:0]  cursor_row_r, cursor_row_nxt;
  logic [COL_W-1:0]  cursor_col_r, cursor_col_nxt;
  logic [ROW_W-1:0]  cur_phys_r, cur_phys_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [ROWS-1:0]   row_vld_r, row_vld_nxt;
  logic [7:0]        char_r, char_nxt;
  logic [ROW_W-1:0]  rd_phys_r, rd_phys_nxt;
  logic [6:0]        rd_col_r, rd_col_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              accept;
  logic              is_nl;
  logic [COL_W:0]    col_inc;
  logic              wrap;
  logic [ROW_W-1:0]  phys_inc;
  logic [ROW_W:0]    rd_sum;

  logic              cell_we;
  logic [ADDR_W-1:0] cell_waddr, cell_raddr;
  logic [15:0]       cell_wdata, cell_rdata;
  logic              meta_we;
  logic [ROW_W-1:0]  meta_waddr, meta_raddr;
  meta_t             meta_wdata, meta_rdata;
  meta_t             meta_eff;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  assign is_nl    = (char_r == NEWLINE_CODE);
  assign col_inc  = (COL_W+1)'(cursor_col_r) + 1'b1;
  assign wrap     = is_nl || (col_inc == (COL_W+1)'(COLUMNS));
  assign phys_inc = (cur_phys_r == ROW_W'(ROWS - 1)) ? '0 : cur_phys_r + 1'b1;

  // logical row to physical row through the rotating top pointer
  assign rd_sum = (ROW_W+1)'(top_r) + (ROW_W+1)'(ROW_W'(in_data.read_row));

  // a row not yet valid is fresh from reset: empty, blank color 0x0A
  assign meta_eff.color = row_vld_r[rd_phys_r] ? meta_rdata.color : RESET_COLOR;
  assign meta_eff.fill  = row_vld_r[rd_phys_r] ? meta_rdata.fill  : '0;

  always_comb begin
    cell_we    = (state_r == ST_PUT) && !is_nl;
    cell_waddr = ADDR_W'(32'(cur_phys_r) * COLUMNS) + ADDR_W'(cursor_col_r);
    cell_wdata = {text_color_r, char_r};
    cell_raddr = ADDR_W'(32'(rd_phys_r) * COLUMNS) + ADDR_W'(rd_col_r);

    meta_we    = ((state_r == ST_PUT) && !is_nl) || (state_r == ST_SCROLL);
    meta_waddr = cur_phys_r;
    meta_raddr = rd_phys_r;
    if (state_r == ST_SCROLL) begin
      meta_wdata.color = text_color_r;
      meta_wdata.fill  = '0;
    end else begin
      meta_wdata.color = cur_color_r;
      meta_wdata.fill  = FILL_W'(col_inc);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    text_color_nxt = text_color_r;
    cur_color_nxt  = cur_color_r;
    cursor_row_nxt = cursor_row_r;
    cursor_col_nxt = cursor_col_r;
    cur_phys_nxt   = cur_phys_r;
    top_nxt        = top_r;
    row_vld_nxt    = row_vld_r;
    char_nxt       = char_r;
    rd_phys_nxt    = rd_phys_r;
    rd_col_nxt     = rd_col_r;
    rd_ok_nxt      = rd_ok_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;

    if (cfg_valid && cfg_ready) begin
      text_color_nxt = cfg_data;
    end
    if (meta_we) begin
      row_vld_nxt[meta_waddr] = 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          char_nxt    = in_data.char_code;
          rd_col_nxt  = in_data.read_col;
          rd_ok_nxt   = (32'(in_data.read_row) < 32'(ROWS)) &&
                        (32'(in_data.read_col) < 32'(COLUMNS));
          rd_phys_nxt = (rd_sum >= (ROW_W+1)'(ROWS)) ?
                        ROW_W'(rd_sum - (ROW_W+1)'(ROWS)) : ROW_W'(rd_sum);
          state_nxt   = (in_data.mode == MODE_READ) ? ST_RD_ADDR : ST_PUT;
        end
      end
      ST_PUT: begin
        state_nxt                = ST_IDLE;
        out_data_nxt.cell_value  = '0;
        out_data_nxt.scrolled    = 1'b0;
        cursor_col_nxt           = wrap ? '0 : COL_W'(col_inc);
        if (wrap) begin
          cur_phys_nxt = phys_inc;
          if (cursor_row_r == ROW_W'(ROWS - 1)) begin
            state_nxt = ST_SCROLL;
          end else begin
            // rows below the cursor are untouched since reset
            cursor_row_nxt = cursor_row_r + 1'b1;
            cur_color_nxt  = RESET_COLOR;
          end
        end
        out_data_nxt.cursor_row = 5'(cursor_row_nxt);
        out_data_nxt.cursor_col = 7'(cursor_col_nxt);
        out_strobe_nxt          = (state_nxt == ST_IDLE);
      end
      ST_SCROLL: begin
        // old top row becomes the blank bottom row
        top_nxt               = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;
        cur_color_nxt         = text_color_r;
        out_data_nxt.scrolled = 1'b1;
        out_strobe_nxt        = 1'b1;
        state_nxt             = ST_IDLE;
      end
      ST_RD_ADDR: begin
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (!rd_ok_r) begin
          out_data_nxt.cell_value = '0;
        end else if (32'(rd_col_r) < 32'(meta_eff.fill)) begin
          out_data_nxt.cell_value = cell_rdata;
        end else begin
          out_data_nxt.cell_value = {meta_eff.color, SPACE_CODE};
        end
        out_data_nxt.cursor_row = 5'(cursor_row_r);
        out_data_nxt.cursor_col = 7'(cursor_col_r);
        out_data_nxt.scrolled   = 1'b0;
        out_strobe_nxt          = 1'b1;
        state_nxt               = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      text_color_r <= RESET_COLOR;
      cur_color_r  <= RESET_COLOR;
      cursor_row_r <= '0;
      cursor_col_r <= '0;
      cur_phys_r   <= '0;
      top_r        <= '0;
      row_vld_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      text_color_r <= text_color_nxt;
      cur_color_r  <= cur_color_nxt;
      cursor_row_r <= cursor_row_nxt;
      cursor_col_r <= cursor_col_nxt;
      cur_phys_r   <= cur_phys_nxt;
      top_r        <= top_nxt;
      row_vld_r    <= row_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    rd_phys_r  <= rd_phys_nxt;
    rd_col_r   <= rd_col_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  tmtw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  tmtw_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (ROWS)
  ) u_row_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  // result beat only follows a cycle of work
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without work in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not start work");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result beats in a row");

  a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.scrolled |-> out_data.cursor_row == 5'(ROWS - 1))
    else $error("scroll left cursor off the last row");

  a_cursor_top_phys: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && cursor_row_r == ROW_W'(ROWS - 1) |->
      ((top_r == '0) ? cur_phys_r == ROW_W'(ROWS - 1) : cur_phys_r == top_r - 1'b1)
      || (cur_phys_r == ROW_W'(ROWS - 1) && top_r == '0))
    else $error("cursor physical row out of step with top pointer");

endmodule
